// ===== hw/rtl/tstp_pkg.sv =====
// Types and character constants for the timestamp text parser.
package tstp_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] year_type;
   typedef logic [7:0]  narrow_type;

   localparam byte_type CHAR_ZERO = 8'h30;
   localparam byte_type CHAR_NINE = 8'h39;

   localparam logic [15:0] ACC_MAX    = 16'hFFFF;
   localparam narrow_type  NARROW_MAX = 8'hFF;

   typedef enum logic [2:0] {
      PH_WAIT   = 3'b001,
      PH_FIELDS = 3'b010,
      PH_TAIL   = 3'b100
   } phase_type;

   localparam logic [2:0] FLD_YEAR   = 3'd0;
   localparam logic [2:0] FLD_MONTH  = 3'd1;
   localparam logic [2:0] FLD_DAY    = 3'd2;
   localparam logic [2:0] FLD_HOUR   = 3'd3;
   localparam logic [2:0] FLD_MINUTE = 3'd4;

   function automatic narrow_type sat8(input logic [15:0] v);
      return (v > {8'h00, NARROW_MAX}) ? NARROW_MAX : v[7:0];
   endfunction

endpackage

// ===== hw/rtl/timestamp_text_parser_unit.sv =====
// Timestamp text parser: quoted yyyy-mm-ddThh:mm:ssZ text in, one byte word at a time.
//
// Request channel: req_in_byte carries the next character; req_first set marks the
// opening quote of a new string and abandons any parse in progress. Any byte seen
// while idle is taken as the opening quote. Six decimal fields follow, each ended
// by any non-digit; after the seconds field the terminator and one more byte are
// skipped, and on that byte one response word carries all six fields.
// A field with no digit gives a response with rsp_parse_ok low and all fields zero.
// The year saturates at 65535, the other fields at 255.
//
// One word is taken every cycle while req_stall is low. A byte is held in an input
// register, then the parse step (compare, multiply by ten, add) runs from it into the
// response register, which takes the response that the byte causes.
// A stalled response holds; the input register still drains unless it has a
// response of its own to load, so req_stall rises only behind a stalled response.
// Reset returns the parser to idle and drops any word held inside.
module timestamp_text_parser_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tstp_pkg::byte_type   req_in_byte,
   input  logic                 req_first,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_parse_ok,
   output tstp_pkg::year_type   rsp_year,
   output tstp_pkg::narrow_type rsp_month,
   output tstp_pkg::narrow_type rsp_day,
   output tstp_pkg::narrow_type rsp_hour,
   output tstp_pkg::narrow_type rsp_minute,
   output tstp_pkg::narrow_type rsp_second
);
   import tstp_pkg::*;

   logic       in_valid_ff;
   byte_type   in_byte_ff;
   logic       in_first_ff;

   phase_type   phase_ff, phase_in;
   logic [2:0]  field_ff, field_in;
   logic [15:0] acc_ff, acc_in;
   logic        seen_ff, seen_in;
   year_type    year_ff, year_in;
   narrow_type  month_ff, month_in;
   narrow_type  day_ff, day_in;
   narrow_type  hour_ff, hour_in;
   narrow_type  minute_ff, minute_in;

   logic        rsp_valid_ff;
   logic        rsp_ok_ff, rsp_ok_in;
   year_type    rsp_year_ff, rsp_year_in;
   narrow_type  rsp_month_ff, rsp_month_in;
   narrow_type  rsp_day_ff, rsp_day_in;
   narrow_type  rsp_hour_ff, rsp_hour_in;
   narrow_type  rsp_minute_ff, rsp_minute_in;
   narrow_type  rsp_second_ff, rsp_second_in;

   logic        advance;
   logic        emit;
   logic        is_digit;
   logic [19:0] acc_next;

   assign advance   = in_valid_ff && (!emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign is_digit = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {16'h0000, in_byte_ff[3:0]};

   always_comb begin
      phase_in      = phase_ff;
      field_in      = field_ff;
      acc_in        = acc_ff;
      seen_in       = seen_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      emit          = 1'b0;
      rsp_ok_in     = 1'b0;
      rsp_year_in   = '0;
      rsp_month_in  = '0;
      rsp_day_in    = '0;
      rsp_hour_in   = '0;
      rsp_minute_in = '0;
      rsp_second_in = '0;
      if (in_first_ff || (phase_ff != PH_FIELDS && phase_ff != PH_TAIL)) begin
         phase_in = PH_FIELDS;
         field_in = FLD_YEAR;
         acc_in   = '0;
         seen_in  = 1'b0;
      end else if (phase_ff == PH_TAIL) begin
         emit          = 1'b1;
         rsp_ok_in     = 1'b1;
         rsp_year_in   = year_ff;
         rsp_month_in  = month_ff;
         rsp_day_in    = day_ff;
         rsp_hour_in   = hour_ff;
         rsp_minute_in = minute_ff;
         rsp_second_in = sat8(acc_ff);
         phase_in      = PH_WAIT;
      end else if (is_digit) begin
         acc_in  = (acc_next > {4'h0, ACC_MAX}) ? ACC_MAX : acc_next[15:0];
         seen_in = 1'b1;
      end else if (!seen_ff) begin
         emit     = 1'b1;
         phase_in = PH_WAIT;
         field_in = FLD_YEAR;
         acc_in   = '0;
      end else begin
         seen_in  = 1'b0;
         field_in = field_ff + 3'd1;
         acc_in   = '0;
         unique case (field_ff)
            FLD_YEAR:   year_in   = acc_ff;
            FLD_MONTH:  month_in  = sat8(acc_ff);
            FLD_DAY:    day_in    = sat8(acc_ff);
            FLD_HOUR:   hour_in   = sat8(acc_ff);
            FLD_MINUTE: minute_in = sat8(acc_ff);
            default: begin
               // seconds done: keep them in the accumulator for the tail byte
               phase_in = PH_TAIL;
               field_in = field_ff;
               acc_in   = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_in_byte;
         in_first_ff <= req_first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         field_ff  <= FLD_YEAR;
         acc_ff    <= '0;
         seen_ff   <= 1'b0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         field_ff  <= field_in;
         acc_ff    <= acc_in;
         seen_ff   <= seen_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ok_ff     <= rsp_ok_in;
         rsp_year_ff   <= rsp_year_in;
         rsp_month_ff  <= rsp_month_in;
         rsp_day_ff    <= rsp_day_in;
         rsp_hour_ff   <= rsp_hour_in;
         rsp_minute_ff <= rsp_minute_in;
         rsp_second_ff <= rsp_second_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_parse_ok = rsp_ok_ff;
   assign rsp_year     = rsp_year_ff;
   assign rsp_month    = rsp_month_ff;
   assign rsp_day      = rsp_day_ff;
   assign rsp_hour     = rsp_hour_ff;
   assign rsp_minute   = rsp_minute_ff;
   assign rsp_second   = rsp_second_ff;

endmodule

// ===== hw/rtl/tstp_checker.sv =====
// Port-level checks for the timestamp text parser, bound to the parser module.
module tstp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_parse_ok,
   input tstp_pkg::year_type   rsp_year,
   input tstp_pkg::narrow_type rsp_month,
   input tstp_pkg::narrow_type rsp_day,
   input tstp_pkg::narrow_type rsp_hour,
   input tstp_pkg::narrow_type rsp_minute,
   input tstp_pkg::narrow_type rsp_second
);
   import tstp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_parse_ok) && $stable(rsp_year)
         && $stable(rsp_second))
      else $error("stalled response word changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_parse_ok |-> rsp_year == '0 && rsp_month == '0 && rsp_day == '0
         && rsp_hour == '0 && rsp_minute == '0 && rsp_second == '0)
      else $error("failure word carries non-zero fields");

   a_free_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with response register empty");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind timestamp_text_parser_unit tstp_checker u_tstp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_parse_ok (rsp_parse_ok),
   .rsp_year     (rsp_year),
   .rsp_month    (rsp_month),
   .rsp_day      (rsp_day),
   .rsp_hour     (rsp_hour),
   .rsp_minute   (rsp_minute),
   .rsp_second   (rsp_second)
);

// ===== tb/tb_timestamp_text_parser_unit.sv =====
// Testbench for the timestamp text parser: directed and random streams against a local model.
module tb_timestamp_text_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import tstp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;

   localparam byte_type QUOTE_CHAR = 8'h22;
   localparam byte_type DASH_CHAR  = 8'h2D;
   localparam byte_type T_CHAR     = 8'h54;
   localparam byte_type COLON_CHAR = 8'h3A;
   localparam byte_type Z_CHAR     = 8'h5A;

   typedef struct packed {
      logic       ok;
      year_type   year;
      narrow_type month;
      narrow_type day;
      narrow_type hour;
      narrow_type minute;
      narrow_type second;
   } stamp_fields_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   byte_type   req_in_byte = '0;
   logic       req_first = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_parse_ok;
   year_type   rsp_year;
   narrow_type rsp_month;
   narrow_type rsp_day;
   narrow_type rsp_hour;
   narrow_type rsp_minute;
   narrow_type rsp_second;

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned chars_sent = 0;
   int unsigned fault_count = 0;
   int unsigned cycle_count = 0;

   stamp_fields_type expected_stamps[$];

   // parser model state
   phase_type  model_phase = PH_WAIT;
   logic [2:0] model_field = FLD_YEAR;
   logic [15:0] model_acc = '0;
   logic       model_seen = 1'b0;
   year_type   model_year = '0;
   narrow_type model_month = '0;
   narrow_type model_day = '0;
   narrow_type model_hour = '0;
   narrow_type model_minute = '0;

   timestamp_text_parser_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_first    (req_first),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_parse_ok (rsp_parse_ok),
      .rsp_year     (rsp_year),
      .rsp_month    (rsp_month),
      .rsp_day      (rsp_day),
      .rsp_hour     (rsp_hour),
      .rsp_minute   (rsp_minute),
      .rsp_second   (rsp_second)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic narrow_type clamp_narrow(input logic [15:0] v);
      return (v > 16'd255) ? NARROW_MAX : v[7:0];
   endfunction

   function automatic void predict_stamp(input byte_type b, input logic f);
      stamp_fields_type r;
      int unsigned      v;
      if (f || (model_phase != PH_FIELDS && model_phase != PH_TAIL)) begin
         model_phase = PH_FIELDS;
         model_field = FLD_YEAR;
         model_acc   = '0;
         model_seen  = 1'b0;
      end else if (model_phase == PH_TAIL) begin
         r.ok     = 1'b1;
         r.year   = model_year;
         r.month  = model_month;
         r.day    = model_day;
         r.hour   = model_hour;
         r.minute = model_minute;
         r.second = clamp_narrow(model_acc);
         expected_stamps.push_back(r);
         model_phase = PH_WAIT;
      end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         v = model_acc * 10 + (b - CHAR_ZERO);
         model_acc  = (v > 32'd65535) ? ACC_MAX : v[15:0];
         model_seen = 1'b1;
      end else if (!model_seen) begin
         r = '0;
         expected_stamps.push_back(r);
         model_phase = PH_WAIT;
         model_field = FLD_YEAR;
         model_acc   = '0;
      end else begin
         case (model_field)
            FLD_YEAR:   model_year   = model_acc;
            FLD_MONTH:  model_month  = clamp_narrow(model_acc);
            FLD_DAY:    model_day    = clamp_narrow(model_acc);
            FLD_HOUR:   model_hour   = clamp_narrow(model_acc);
            FLD_MINUTE: model_minute = clamp_narrow(model_acc);
            default: begin
               model_phase = PH_TAIL;
               model_seen  = 1'b0;
            end
         endcase
         if (model_phase == PH_FIELDS) begin
            model_field = model_field + 3'd1;
            model_acc   = '0;
            model_seen  = 1'b0;
         end
      end
   endfunction

   function automatic void check_stamp();
      stamp_fields_type got;
      stamp_fields_type want;
      got = {rsp_parse_ok, rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second};
      if (expected_stamps.size() == 0) begin
         if (fault_count < 10)
            $display("unexpected word: ok=%0d %0d-%0d-%0d %0d:%0d:%0d", got.ok, got.year,
                     got.month, got.day, got.hour, got.minute, got.second);
         fault_count++;
      end else begin
         want = expected_stamps.pop_front();
         if (got.ok !== want.ok || got.year !== want.year || got.month !== want.month ||
             got.day !== want.day || got.hour !== want.hour ||
             got.minute !== want.minute || got.second !== want.second) begin
            if (fault_count < 10)
               $display(
                  "mismatch: exp ok=%0d %0d-%0d-%0d %0d:%0d:%0d got ok=%0d %0d-%0d-%0d %0d:%0d:%0d",
                  want.ok, want.year, want.month, want.day, want.hour, want.minute,
                  want.second, got.ok, got.year, got.month, got.day, got.hour,
                  got.minute, got.second);
            fault_count++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_stamp();
         rsp_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
      end
   end

   function automatic byte_type random_non_digit();
      byte_type c;
      do
         c = byte_type'($urandom_range(255, 0));
      while (c >= CHAR_ZERO && c <= CHAR_NINE);
      return c;
   endfunction

   task automatic send_char(input byte_type b, input logic f);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_first   <= f;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_stamp(b, f);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], 1'b0);
   endtask

   // idle byte taken as quote, year overflow, month and second clamped, 0x00/0xFF separators
   task automatic test_idle_start_and_saturation();
      send_char(8'hFF, 1'b0);
      send_text("70000");
      send_char(8'h00, 1'b0);
      send_text("256");
      send_char(8'hFF, 1'b0);
      send_text("9");
      send_char(T_CHAR, 1'b0);
      send_text("0");
      send_char(COLON_CHAR, 1'b0);
      send_text("0");
      send_char(COLON_CHAR, 1'b0);
      send_text("999");
      send_char(Z_CHAR, 1'b0);
      send_char(QUOTE_CHAR, 1'b0);
   endtask

   // restart mid-field, then a field with no digits
   task automatic test_empty_and_abandoned();
      send_char(QUOTE_CHAR, 1'b1);
      send_text("5");
      send_char(QUOTE_CHAR, 1'b1);
      send_char(COLON_CHAR, 1'b0);
   endtask

   task automatic send_timestamp(input logic open_first, output logic cut_short);
      int unsigned digits;
      int unsigned r;
      byte_type    sep;
      cut_short = 1'b0;
      send_char(($urandom_range(3, 0) == 0) ? byte_type'($urandom_range(255, 0)) : QUOTE_CHAR,
                open_first);
      for (int fld = 0; fld < 6; fld++) begin
         if ($urandom_range(99, 0) < 3) begin
            cut_short = 1'b1;
            return;
         end
         r = $urandom_range(99, 0);
         if (r < 4)
            digits = 0;
         else if (r < 12)
            digits = $urandom_range(7, 5);
         else
            digits = $urandom_range((fld == 0) ? 4 : 2, 1);
         for (int d = 0; d < digits; d++)
            send_char(CHAR_ZERO + byte_type'($urandom_range(9, 0)), 1'b0);
         if ($urandom_range(2, 0) == 0)
            sep = random_non_digit();
         else if (fld < 2)
            sep = DASH_CHAR;
         else if (fld == 2)
            sep = T_CHAR;
         else if (fld < 5)
            sep = COLON_CHAR;
         else
            sep = Z_CHAR;
         send_char(sep, 1'b0);
         if (digits == 0)
            return;
      end
      send_char(($urandom_range(3, 0) == 0) ? byte_type'($urandom_range(255, 0)) : QUOTE_CHAR,
                1'b0);
   endtask

   task automatic test_random_streams(input int unsigned char_budget);
      int unsigned stop_at;
      logic        force_first;
      logic        cut_short;
      stop_at     = chars_sent + char_budget;
      force_first = 1'b1;
      while (chars_sent < stop_at) begin
         if ($urandom_range(99, 0) < 8) begin
            send_char(byte_type'($urandom_range(255, 0)), $urandom_range(9, 0) == 0);
         end else begin
            send_timestamp(force_first || ($urandom_range(3, 0) != 0), cut_short);
            force_first = cut_short;
         end
      end
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (expected_stamps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fault_count += expected_stamps.size();
      if (fault_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   endtask

   initial begin
      sender_idle_pct    = 14;
      receiver_stall_pct = 78;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_idle_start_and_saturation();
      test_empty_and_abandoned();
      test_random_streams(430);
      sender_idle_pct    = 78;
      receiver_stall_pct = 14;
      test_random_streams(450);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      test_random_streams(450);
      finish_run();
   end

endmodule
